>>> hw/rtl/circle_point_generator_defines.svh
// assertion macros shared by the circle point generator rtl
// no dependencies; included by the files that carry assertions
`ifndef CIRCLE_POINT_GENERATOR_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_DEFINES_SVH

// property checked on every rising edge, suspended while reset is held
`define CPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define CPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/cpg_pkg.sv
// shared types, constants and the octant map of the circle point generator
// no dependencies
package cpg_pkg;

    // default coordinate width of centre and radius
    localparam int CPG_COORD_BITS = 10;
    // width of the emitted point coordinates
    localparam int PT_BITS        = 12;
    // points emitted per step
    localparam int POINTS         = 8;
    localparam int CNT_BITS       = $clog2(POINTS);

    // operation codes of an input word
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // how one of the eight symmetric points is formed from (x, y)
    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } t_octant;

    // controller to datapath commands
    typedef struct packed {
        logic                load;
        logic                update;
        logic [CNT_BITS-1:0] sel;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic done;
    } t_stat;

    // order (x,y) (y,x) (-x,y) (y,-x) (-x,-y) (-y,-x) (x,-y) (-y,x)
    function automatic t_octant octant_map(input logic [CNT_BITS-1:0] sel);
        t_octant o;
        case (sel)
            3'd0:    o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
            3'd1:    o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
            3'd2:    o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
            3'd3:    o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
            3'd4:    o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
            3'd5:    o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
            3'd6:    o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
            3'd7:    o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
            default: o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
        endcase
        return o;
    endfunction

endpackage

>>> hw/rtl/cpg_dp.sv
// datapath: held centre, octant offsets, decision value and point adders
// depends on cpg_pkg
module cpg_dp #(
    parameter int COORD_BITS = cpg_pkg::CPG_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpg_pkg::t_cmd                       i_cmd,
    output cpg_pkg::t_stat                      o_stat,
    input  logic [COORD_BITS-1:0]               i_center_x,
    input  logic [COORD_BITS-1:0]               i_center_y,
    input  logic [COORD_BITS-1:0]               i_radius,
    output logic signed [cpg_pkg::PT_BITS-1:0]  o_point_x,
    output logic signed [cpg_pkg::PT_BITS-1:0]  o_point_y
);
    import cpg_pkg::*;

    localparam int DEC_BITS = COORD_BITS + 4;
    localparam int CMP_BITS = COORD_BITS + 2;
    localparam int WW       = (COORD_BITS > PT_BITS) ? COORD_BITS : PT_BITS;

    logic [COORD_BITS-1:0]      r_cx, r_cy, r_x, r_y;
    logic [COORD_BITS-1:0]      n_x, n_y;
    logic signed [DEC_BITS-1:0] r_dec, n_dec, dec_init;
    logic                       d_neg;
    logic signed [CMP_BITS-1:0] nx_cmp, ny_cmp;
    t_octant                    oct;
    logic [COORD_BITS-1:0]      a_src, b_src;
    logic [WW-1:0]              a_w, b_w, cx_w, cy_w;
    logic [PT_BITS-1:0]         dx, dy;

    // decision update and next offsets, using x and y before they advance
    always_comb begin
        d_neg = r_dec[DEC_BITS-1];
        n_x   = r_x + COORD_BITS'(1);
        if (d_neg) begin
            n_y   = r_y;
            n_dec = r_dec + (DEC_BITS'(r_x) << 2) + DEC_BITS'(6);
        end else begin
            n_y   = r_y - COORD_BITS'(1);
            n_dec = r_dec + (DEC_BITS'(r_x) << 2) - (DEC_BITS'(r_y) << 2)
                    + DEC_BITS'(10);
        end
        dec_init = DEC_BITS'(3) - (DEC_BITS'(i_radius) << 1);
    end

    // done once x would pass y, compared before any wrap
    always_comb begin
        nx_cmp      = signed'(CMP_BITS'(r_x)) + CMP_BITS'(1);
        ny_cmp      = signed'(CMP_BITS'(r_y)) - CMP_BITS'(!d_neg);
        o_stat.done = nx_cmp > ny_cmp;
    end

    // point of the selected octant, offset by the held centre, wraps to PT_BITS
    always_comb begin
        oct       = octant_map(i_cmd.sel);
        a_src     = oct.swap ? r_y : r_x;
        b_src     = oct.swap ? r_x : r_y;
        a_w       = WW'(a_src);
        b_w       = WW'(b_src);
        cx_w      = WW'(r_cx);
        cy_w      = WW'(r_cy);
        dx        = oct.neg_x ? -a_w[PT_BITS-1:0] : a_w[PT_BITS-1:0];
        dy        = oct.neg_y ? -b_w[PT_BITS-1:0] : b_w[PT_BITS-1:0];
        o_point_x = signed'(cx_w[PT_BITS-1:0] + dx);
        o_point_y = signed'(cy_w[PT_BITS-1:0] + dy);
    end

    // state registers: a new circle overrides the end-of-step update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_x   <= '0;
            r_y   <= '0;
            r_dec <= '0;
        end else if (i_cmd.load) begin
            r_cx  <= i_center_x;
            r_cy  <= i_center_y;
            r_x   <= '0;
            r_y   <= i_radius;
            r_dec <= dec_init;
        end else if (i_cmd.update) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_dec <= n_dec;
        end
    end

endmodule

>>> hw/rtl/cpg_ctrl.sv
// controller: command handshake, running flag and point sequencing
// depends on cpg_pkg and circle_point_generator_defines.svh
`include "circle_point_generator_defines.svh"

module cpg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_operation,
    output cpg_pkg::t_cmd  o_cmd,
    input  cpg_pkg::t_stat i_stat,
    output logic           o_valid,
    output logic           o_last_of_step,
    output logic           o_circle_done
);
    import cpg_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_running, n_running;
    logic                accept, last, load, step_go;

    // handshake and sequencing decisions
    always_comb begin
        last    = (r_state == S_EMIT) && (r_cnt == CNT_BITS'(POINTS - 1));
        busy    = (r_state == S_EMIT) && !last;
        accept  = start && !busy;
        load    = accept && (i_operation == OP_START);
        // a step taken on the final point sees the running flag as updated there
        step_go = accept && (i_operation == OP_STEP) && r_running
                  && !(last && i_stat.done);

        n_running = r_running;
        if (load) begin
            n_running = 1'b1;
        end else if (last && i_stat.done) begin
            n_running = 1'b0;
        end

        n_state = r_state;
        n_cnt   = r_cnt;
        if (step_go) begin
            n_state = S_EMIT;
            n_cnt   = '0;
        end else if (last) begin
            n_state = S_IDLE;
            n_cnt   = '0;
        end else if (r_state == S_EMIT) begin
            n_cnt = r_cnt + CNT_BITS'(1);
        end
    end

    // commands and output strobes
    always_comb begin
        o_cmd.load     = load;
        o_cmd.update   = last;
        o_cmd.sel      = r_cnt;
        o_valid        = (r_state == S_EMIT);
        o_last_of_step = last;
        o_circle_done  = (r_state == S_EMIT) && i_stat.done;
    end

    // state, counter and running flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_running <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_running <= n_running;
        end
    end

    // points are only emitted for a live circle
    `CPG_ASSERT(a_emit_running, i_clk, i_rst_n, (r_state == S_EMIT) |-> r_running, "word emitted with no circle running")
    // point index advances by one inside a step
    `CPG_ASSERT(a_cnt_step, i_clk, i_rst_n, ((r_state == S_EMIT) && !last) |=> (r_cnt == $past(r_cnt) + CNT_BITS'(1)), "point index skipped")
    // an accepted step on a live circle starts at the first point
    `CPG_ASSERT(a_step_starts, i_clk, i_rst_n, step_go |=> ((r_state == S_EMIT) && (r_cnt == '0)), "accepted step did not start emission")
    // a finishing step with no new circle leaves nothing running
    `CPG_ASSERT(a_done_clears, i_clk, i_rst_n, (last && i_stat.done && !load) |=> !r_running, "circle still running after its final step")
    // nothing is emitted straight after reset
    `CPG_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> ((r_state == S_IDLE) && !r_running), "emission active after reset")

endmodule

>>> hw/rtl/circle_point_generator.sv
// top level of the Bresenham circle rasteriser: controller plus datapath
// depends on cpg_pkg, cpg_ctrl and cpg_dp
//
// Usage. A command word is taken at a rising edge with start high and busy
// low. Operation start loads centre and radius, emits nothing and frees the
// port at once. Operation step on a running circle emits the eight symmetric
// points of the current octant position, one per cycle, beginning the cycle
// after the word is taken; each point is marked by o_valid for one cycle,
// o_last_of_step flags the eighth, and o_circle_done is high on all eight
// points of the step that completes the circle. A step with no circle
// running is taken and emits nothing.
// Throughput: one point per cycle through the shared point adders; busy drops
// during the eighth point, so the next word may be taken on the edge that
// ends it.
// Reset (synchronous, active low) clears the circle, so no points are
// emitted until a start word arrives. The receiver cannot stall: each point
// is taken at the edge that ends its cycle.
module circle_point_generator #(
    parameter int COORD_BITS = cpg_pkg::CPG_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [COORD_BITS-1:0]               i_center_x,
    input  logic [COORD_BITS-1:0]               i_center_y,
    input  logic [COORD_BITS-1:0]               i_radius,
    output logic                                o_valid,
    output logic signed [cpg_pkg::PT_BITS-1:0]  o_point_x,
    output logic signed [cpg_pkg::PT_BITS-1:0]  o_point_y,
    output logic                                o_last_of_step,
    output logic                                o_circle_done
);
    import cpg_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing and handshake
    cpg_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .o_cmd          (cmd),
        .i_stat         (stat),
        .o_valid        (o_valid),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    // arithmetic and circle state
    cpg_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y)
    );

endmodule

>>> test/circle_point_generator_tb.sv
// self-checking testbench for the Bresenham circle rasteriser circle_point_generator
// depends on cpg_pkg and the circle_point_generator rtl; needs no other file
module circle_point_generator_tb;

    import cpg_pkg::*;

    localparam int CB         = 10;
    localparam int QUIET_MAX  = 2000;
    localparam int RAND_WORDS = 70;

    // one command word as presented to the block
    typedef struct packed {
        logic          op;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-1:0] r;
        bit            drain;
    } t_word;

    // one plotted pixel as it should leave the block
    typedef struct packed {
        logic signed [PT_BITS-1:0] px;
        logic signed [PT_BITS-1:0] py;
        logic                      last;
        logic                      done;
    } t_point;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic                      i_operation = OP_STEP;
    logic [CB-1:0]             i_center_x  = '0;
    logic [CB-1:0]             i_center_y  = '0;
    logic [CB-1:0]             i_radius    = '0;
    logic                      o_valid;
    logic signed [PT_BITS-1:0] o_point_x;
    logic signed [PT_BITS-1:0] o_point_y;
    logic                      o_last_of_step;
    logic                      o_circle_done;

    t_word  pending_words[$];
    t_point expected_points[$];
    t_word  cur_word;
    bit     taken;
    int     words_total;
    int     words_taken;
    int     n_fail;
    int     quiet_cycles;

    // own copy of the rasteriser state
    logic [CB-1:0]   ras_cx;
    logic [CB-1:0]   ras_cy;
    logic [CB-1:0]   ras_x;
    logic [CB-1:0]   ras_y;
    logic [CB+3:0]   ras_dec;
    bit              ras_live;

    circle_point_generator #(
        .COORD_BITS(CB)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .o_valid       (o_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_last_of_step(o_last_of_step),
        .o_circle_done (o_circle_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected points of one accepted word, state advanced as the block does
    function automatic void rasterise(t_word w);
        int     x, y, d, nx, ny, nd, k;
        int     dx[8];
        int     dy[8];
        bit     fin;
        t_point p;
        if (w.op == OP_START) begin
            ras_cx   = w.cx;
            ras_cy   = w.cy;
            ras_x    = '0;
            ras_y    = w.r;
            ras_dec  = (CB+4)'(3 - 2 * int'(w.r));
            ras_live = 1'b1;
            return;
        end
        if (!ras_live)
            return;
        x = int'(ras_x);
        y = int'(ras_y);
        d = int'($signed(ras_dec));
        // decision uses x and y from before the advance
        if (d < 0) begin
            nd = d + 4 * x + 6;
            ny = y;
        end else begin
            nd = d + 4 * (x - y) + 10;
            ny = y - 1;
        end
        nx  = x + 1;
        fin = nx > ny;
        dx  = '{x, y, -x, y, -x, -y, x, -y};
        dy  = '{y, x, y, -x, -y, -x, -y, x};
        for (k = 0; k < POINTS; k++) begin
            p.px   = PT_BITS'(int'(ras_cx) + dx[k]);
            p.py   = PT_BITS'(int'(ras_cy) + dy[k]);
            p.last = (k == POINTS - 1);
            p.done = fin;
            expected_points.push_back(p);
        end
        ras_dec = (CB+4)'(nd);
        ras_x   = CB'(nx);
        ras_y   = CB'(ny);
        if (fin)
            ras_live = 1'b0;
    endfunction

    // number of steps that close a circle of radius r
    function automatic int steps_to_close(int r);
        int x, y, d, n;
        x = 0;
        y = r;
        d = 3 - 2 * r;
        n = 0;
        do begin
            n++;
            if (d < 0) begin
                d += 4 * x + 6;
            end else begin
                d += 4 * (x - y) + 10;
                y--;
            end
            x++;
        end while (x <= y);
        return n;
    endfunction

    task automatic add_start(int cx, int cy, int r, bit drain);
        t_word w;
        w.op    = OP_START;
        w.cx    = CB'(cx);
        w.cy    = CB'(cy);
        w.r     = CB'(r);
        w.drain = drain;
        pending_words.push_back(w);
    endtask

    // step words carry random start fields, which the block must ignore
    task automatic add_steps(int n);
        t_word w;
        repeat (n) begin
            w.op    = OP_STEP;
            w.cx    = CB'($urandom);
            w.cy    = CB'($urandom);
            w.r     = CB'($urandom);
            w.drain = ($urandom_range(99) < 5);
            pending_words.push_back(w);
        end
    endtask

    task automatic report_fail(string what);
        n_fail++;
        if (n_fail <= 10)
            $display("mismatch: %s", what);
    endtask

    // driver: presents queued words, idling by phase, holding start until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                rasterise(cur_word);
                words_taken++;
            end
            if (!start || taken) begin
                if (pending_words.size() != 0
                    && !(pending_words[0].drain && expected_points.size() != 0)
                    && $urandom_range(99) >= ((words_taken < words_total / 3) ? 26 :
                                             (words_taken < 2 * words_total / 3) ? 57 : 0))
                begin
                    cur_word    = pending_words.pop_front();
                    start       <= 1'b1;
                    i_operation <= cur_word.op;
                    i_center_x  <= cur_word.cx;
                    i_center_y  <= cur_word.cy;
                    i_radius    <= cur_word.r;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed point against the oldest expectation
    always @(posedge i_clk) begin
        t_point want;
        t_point got;
        if (i_rst_n && o_valid) begin
            got = '{px: o_point_x, py: o_point_y, last: o_last_of_step, done: o_circle_done};
            if (expected_points.size() == 0) begin
                report_fail($sformatf("unexpected point x=%0d y=%0d last=%0b done=%0b",
                                      got.px, got.py, got.last, got.done));
            end else begin
                want = expected_points.pop_front();
                if (got !== want)
                    report_fail($sformatf(
                        "exp x=%0d y=%0d last=%0b done=%0b got x=%0d y=%0d last=%0b done=%0b",
                        want.px, want.py, want.last, want.done,
                        got.px, got.py, got.last, got.done));
            end
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("circle_point_generator verification failed");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int kind, r, n, rand_words, base;
        n_fail       = 0;
        words_taken  = 0;
        quiet_cycles = 0;
        ras_live     = 1'b0;
        ras_cx       = '0;
        ras_cy       = '0;
        ras_x        = '0;
        ras_y        = '0;
        ras_dec      = '0;

        // directed: idle step, zero radius, extremes, restart while running
        add_steps(1);
        add_start(0, 0, 0, 1'b1);
        add_steps(1);
        add_steps(1);
        add_start(1023, 1023, 1023, 1'b1);
        add_steps(3);
        add_start(512, 300, 5, 1'b0);
        add_steps(steps_to_close(5));
        add_start(0, 0, 1023, 1'b1);
        add_steps(2);
        add_start(1023, 0, 1, 1'b0);
        add_steps(steps_to_close(1) + 1);
        add_start(1, 2, 2, 1'b1);
        add_steps(steps_to_close(2));

        // random: mostly complete circles, some cut short, some stray words
        rand_words = 0;
        while (rand_words < RAND_WORDS) begin
            base = pending_words.size();
            kind = $urandom_range(99);
            if (kind < 70) begin
                r = ($urandom_range(99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 40);
                add_start($urandom_range(0, 1023), $urandom_range(0, 1023), r,
                          $urandom_range(99) < 10);
                add_steps(steps_to_close(r));
            end else if (kind < 90) begin
                r = $urandom_range(0, 1023);
                n = $urandom_range(0, 6);
                add_start($urandom_range(0, 1023), $urandom_range(0, 1023), r, 1'b0);
                add_steps(n < steps_to_close(r) ? n : steps_to_close(r) - 1);
            end else if (kind < 95) begin
                add_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), 1'b0);
            end else begin
                add_steps(1);
            end
            rand_words += pending_words.size() - base;
        end
        words_total = pending_words.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (words_taken == words_total);
        wait (expected_points.size() == 0);
        repeat (12) @(posedge i_clk);
        if (n_fail == 0 && expected_points.size() == 0)
            $display("circle_point_generator verification clean");
        else
            $display("circle_point_generator verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cpg_pkg.sv
hw/rtl/cpg_dp.sv
hw/rtl/cpg_ctrl.sv
hw/rtl/circle_point_generator.sv
test/circle_point_generator_tb.sv
